FILE: rtl/keyframe_linear_player_unit_defines.svh
// Assertion macros for the keyframe linear player unit.
`ifndef KEYFRAME_LINEAR_PLAYER_UNIT_DEFINES_SVH
`define KEYFRAME_LINEAR_PLAYER_UNIT_DEFINES_SVH
`ifndef SYNTH
// Checked on every clock edge, reset included.
`define KFLP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("kflp check failed");
// Checked only outside reset.
`define KFLP_ASSERT_RUN(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kflp check failed");
`else
`define KFLP_ASSERT_ALWAYS(lbl, prop)
`define KFLP_ASSERT_RUN(lbl, prop)
`endif
`endif

FILE: rtl/kflp_pkg.sv
// ----------------------------------------------------------------------------
// kflp_pkg
// Shared types and constants of the keyframe linear player.
// ----------------------------------------------------------------------------
package kflp_pkg;

    localparam int MAX_KEYFRAMES = 128;
    localparam int COORD_WIDTH   = 32;
    localparam int NCOORD        = 4;
    localparam int ADDR_W        = $clog2(MAX_KEYFRAMES);
    localparam int FC_W          = $clog2(MAX_KEYFRAMES + 1);
    localparam int FIELD_W       = 32;
    localparam int SEG_OUT_W     = 7;
    localparam int STEPS_W       = 8;
    localparam int DIV_STEPS     = COORD_WIDTH + 1;
    localparam int DCNT_W        = $clog2(DIV_STEPS);

    localparam logic [STEPS_W-1:0] STEPS_RESET = 8'd10;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAVE   = 2'd1,
        OP_TOGGLE = 2'd2,
        OP_SET    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [FIELD_W-1:0] new_x;
        logic signed [FIELD_W-1:0] new_y;
        logic signed [FIELD_W-1:0] new_z;
        logic signed [FIELD_W-1:0] new_turn;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pose_x;
        logic signed [FIELD_W-1:0] pose_y;
        logic signed [FIELD_W-1:0] pose_z;
        logic signed [FIELD_W-1:0] pose_turn;
        logic                      playing;
        logic [SEG_OUT_W-1:0]      segment;
        logic                      finished;
        logic                      store_full;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_DIFF,
        ST_DIV,
        ST_FIN,
        ST_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic move;
        logic save;
        logic set_pose;
        logic start;
        logic stop;
        logic finish;
        logic adv_seg;
        logic mark_full;
        logic rd_a;
        logic rd_b;
        logic cap_a;
        logic div_start;
        logic inc_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic playing;
        logic cnt_done;
        logic last_seg;
        logic full;
        logic multi_frame;
        logic div_busy;
        logic out_busy;
    } status_t;

endpackage

FILE: rtl/kflp_divider.sv
// ----------------------------------------------------------------------------
// kflp_divider
// Four-lane restoring divider: signed magnitude by an 8-bit divisor, one
// quotient bit per lane per cycle, result truncated toward zero and wrapped.
// ----------------------------------------------------------------------------
module kflp_divider
    import kflp_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [NCOORD-1:0][COORD_WIDTH:0]    mag,
    input  logic [NCOORD-1:0]                   sign,
    input  logic [STEPS_W-1:0]                  divisor,
    output logic [NCOORD-1:0][COORD_WIDTH-1:0]  quot,
    output logic                                busy
);

    logic [NCOORD-1:0][STEPS_W-1:0]  rem_reg, rem_next;
    logic [NCOORD-1:0][COORD_WIDTH:0] q_reg, q_next;
    logic [NCOORD-1:0]               sign_reg;
    logic [STEPS_W-1:0]              dvs_reg;
    logic [DCNT_W-1:0]               cnt_reg;
    logic                            busy_reg;

    always_comb
    begin
        logic [STEPS_W:0] t;
        logic             ge;
        logic [STEPS_W:0] d;
        for (int c = 0; c < NCOORD; c++)
        begin
            t  = {rem_reg[c], q_reg[c][COORD_WIDTH]};
            ge = (t >= {1'b0, dvs_reg});
            d  = t - {1'b0, dvs_reg};
            rem_next[c] = ge ? d[STEPS_W-1:0] : t[STEPS_W-1:0];
            q_next[c]   = {q_reg[c][COORD_WIDTH-1:0], ge};
        end
    end

    always_comb
    begin
        logic [COORD_WIDTH:0] neg;
        for (int c = 0; c < NCOORD; c++)
        begin
            neg     = ~q_reg[c] + 1'b1;
            quot[c] = sign_reg[c] ? neg[COORD_WIDTH-1:0] : q_reg[c][COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            q_reg    <= mag;
            sign_reg <= sign;
            dvs_reg  <= (divisor == '0) ? STEPS_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: rtl/kflp_datapath.sv
// ----------------------------------------------------------------------------
// kflp_datapath
// Pose, increment and playback registers, keyframe memory, increment
// divider and the result register.
// ----------------------------------------------------------------------------
module kflp_datapath
    import kflp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  in_item_t           in_data,
    input  cmd_t               cmd,
    input  logic               cfg_valid,
    input  logic [STEPS_W-1:0] cfg_data,
    input  logic               out_stall,
    output logic               out_valid,
    output out_item_t          out_data,
    output status_t            sts
);

    logic [NCOORD-1:0][COORD_WIDTH-1:0] pose_reg, pose_next;
    logic [NCOORD-1:0][COORD_WIDTH-1:0] inc_reg;
    logic [NCOORD-1:0][COORD_WIDTH-1:0] a_reg;
    logic [ADDR_W-1:0]                  seg_reg;
    logic [STEPS_W-1:0]                 cnt_reg;
    logic                               play_reg;
    logic [FC_W-1:0]                    fc_reg;
    logic [STEPS_W-1:0]                 steps_reg;
    logic                               fin_reg;
    logic                               full_reg;
    logic                               out_valid_reg;
    out_item_t                          out_reg;

    logic [NCOORD*COORD_WIDTH-1:0]      mem [MAX_KEYFRAMES];
    logic [NCOORD*COORD_WIDTH-1:0]      rdata_reg;
    logic                               rd_zero_reg;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [NCOORD-1:0][COORD_WIDTH-1:0] rd_coord;

    logic [NCOORD-1:0][COORD_WIDTH:0]   mag;
    logic [NCOORD-1:0]                  sign;
    logic [NCOORD-1:0][COORD_WIDTH-1:0] quot;
    logic                               div_busy;

    // entry 0 is never written and always reads as zero
    assign rd_addr  = cmd.rd_b ? seg_reg + 1'b1 : seg_reg;
    assign rd_coord = rd_zero_reg ? '0 : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.save)
        begin
            mem[fc_reg[ADDR_W-1:0]] <= pose_reg;
        end
        if (cmd.rd_a || cmd.rd_b)
        begin
            rdata_reg   <= mem[rd_addr];
            rd_zero_reg <= (rd_addr == '0);
        end
    end

    always_comb
    begin
        logic [COORD_WIDTH:0] diff;
        for (int c = 0; c < NCOORD; c++)
        begin
            diff    = {rd_coord[c][COORD_WIDTH-1], rd_coord[c]}
                    - {a_reg[c][COORD_WIDTH-1], a_reg[c]};
            sign[c] = diff[COORD_WIDTH];
            mag[c]  = diff[COORD_WIDTH] ? ~diff + 1'b1 : diff;
        end
    end

    kflp_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .mag     (mag),
        .sign    (sign),
        .divisor (steps_reg),
        .quot    (quot),
        .busy    (div_busy)
    );

    always_comb
    begin
        pose_next = pose_reg;
        if (cmd.move)
        begin
            for (int c = 0; c < NCOORD; c++)
            begin
                pose_next[c] = pose_reg[c] + inc_reg[c];
            end
        end
        else if (cmd.set_pose)
        begin
            pose_next[3] = COORD_WIDTH'(in_data.new_x);
            pose_next[2] = COORD_WIDTH'(in_data.new_y);
            pose_next[1] = COORD_WIDTH'(in_data.new_z);
            pose_next[0] = COORD_WIDTH'(in_data.new_turn);
        end
        else if (cmd.start)
        begin
            pose_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg      <= '0;
            inc_reg       <= '0;
            seg_reg       <= '0;
            cnt_reg       <= '0;
            play_reg      <= 1'b0;
            fc_reg        <= FC_W'(1);
            steps_reg     <= STEPS_RESET;
            fin_reg       <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pose_reg <= pose_next;
            if (cfg_valid)
            begin
                steps_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                fin_reg  <= cmd.finish;
                full_reg <= cmd.mark_full;
            end
            if (cmd.move)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.save)
            begin
                fc_reg <= fc_reg + 1'b1;
            end
            if (cmd.start)
            begin
                play_reg <= 1'b1;
                seg_reg  <= '0;
                cnt_reg  <= '0;
            end
            if (cmd.stop)
            begin
                play_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                play_reg <= 1'b0;
                seg_reg  <= '0;
            end
            if (cmd.adv_seg)
            begin
                seg_reg <= seg_reg + 1'b1;
                cnt_reg <= '0;
            end
            if (cmd.inc_load)
            begin
                inc_reg <= quot;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            a_reg <= rd_coord;
        end
        if (cmd.out_load)
        begin
            out_reg.pose_x     <= FIELD_W'(signed'(pose_reg[3]));
            out_reg.pose_y     <= FIELD_W'(signed'(pose_reg[2]));
            out_reg.pose_z     <= FIELD_W'(signed'(pose_reg[1]));
            out_reg.pose_turn  <= FIELD_W'(signed'(pose_reg[0]));
            out_reg.playing    <= play_reg;
            out_reg.segment    <= SEG_OUT_W'(seg_reg);
            out_reg.finished   <= fin_reg;
            out_reg.store_full <= full_reg;
        end
    end

    always_comb
    begin
        logic [FC_W:0] seg_end;
        seg_end         = (FC_W + 1)'(seg_reg) + (FC_W + 1)'(3);
        sts.playing     = play_reg;
        sts.cnt_done    = (cnt_reg >= steps_reg);
        sts.last_seg    = (seg_end > {1'b0, fc_reg});
        sts.full        = (fc_reg >= FC_W'(MAX_KEYFRAMES));
        sts.multi_frame = (fc_reg > FC_W'(1));
        sts.div_busy    = div_busy;
        sts.out_busy    = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/kflp_controller.sv
// ----------------------------------------------------------------------------
// kflp_controller
// Sequencer: decodes each request, runs the increment computation and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module kflp_controller
    import kflp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  op_t         operation,
    input  status_t     sts,
    output logic        in_stall,
    output cmd_t        cmd,
    output ctrl_state_t state
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RESP;
                    if (operation == OP_TICK && sts.playing && sts.cnt_done
                        && !sts.last_seg)
                    begin
                        state_next = ST_RD_A;
                    end
                    if (operation == OP_TOGGLE && !sts.playing && sts.multi_frame)
                    begin
                        state_next = ST_RD_A;
                    end
                end
            end
            ST_RD_A: state_next = ST_RD_B;
            ST_RD_B: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_DIV;
            ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:  state_next = ST_RESP;
            ST_RESP:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (operation)
                        OP_TICK:
                        begin
                            if (sts.playing)
                            begin
                                if (!sts.cnt_done)
                                begin
                                    cmd.move = 1'b1;
                                end
                                else if (sts.last_seg)
                                begin
                                    cmd.finish = 1'b1;
                                end
                                else
                                begin
                                    cmd.adv_seg = 1'b1;
                                end
                            end
                        end
                        OP_SAVE:
                        begin
                            if (sts.full)
                            begin
                                cmd.mark_full = 1'b1;
                            end
                            else
                            begin
                                cmd.save = 1'b1;
                            end
                        end
                        OP_TOGGLE:
                        begin
                            if (!sts.playing && sts.multi_frame)
                            begin
                                cmd.start = 1'b1;
                            end
                            else
                            begin
                                cmd.stop = 1'b1;
                            end
                        end
                        OP_SET:  cmd.set_pose = 1'b1;
                        default: cmd.set_pose = 1'b0;
                    endcase
                end
            end
            ST_RD_A: cmd.rd_a = 1'b1;
            ST_RD_B:
            begin
                cmd.rd_b  = 1'b1;
                cmd.cap_a = 1'b1;
            end
            ST_DIFF: cmd.div_start = 1'b1;
            ST_DIV:  cmd.inc_load  = 1'b0;
            ST_FIN:  cmd.inc_load  = 1'b1;
            ST_RESP: cmd.out_load  = !sts.out_busy;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

FILE: rtl/keyframe_linear_player_unit.sv
// ----------------------------------------------------------------------------
// keyframe_linear_player_unit
// Keyframe store and linear pose interpolation player.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data) takes one request: tick,
// save pose, play/stop toggle or set pose. Every request gives exactly one
// result on the output channel (out_valid / out_stall / out_data) holding
// the pose and playback status after that request.
// Most requests pass from ST_IDLE straight to ST_RESP, where the result is
// loaded into the output register once it is free. A request that starts
// playback or moves to a new segment reads two keyframes from the store
// (ST_RD_A, ST_RD_B), starts the four-lane bit-serial divider (ST_DIFF), waits
// for it (ST_DIV), then loads the increments (ST_FIN) and the output register
// (ST_RESP).
// One request is in work at a time; in_stall is high until its result has
// been written to the output register.
// A stalled result holds in the output register; the next request is not
// finished while it waits.
// The steps register is written through cfg_valid / cfg_ready / cfg_data
// and is always ready. Reset brings the steps setting to 10, one keyframe
// (all zero), zero pose and stopped playback.
// ----------------------------------------------------------------------------
`include "keyframe_linear_player_unit_defines.svh"

module keyframe_linear_player_unit
    import kflp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [STEPS_W-1:0] cfg_data
);

    cmd_t        cmd;
    status_t     sts;
    ctrl_state_t state;

    assign cfg_ready = 1'b1;

    kflp_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (in_data.operation),
        .sts       (sts),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .state     (state)
    );

    kflp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .sts       (sts)
    );

    `KFLP_ASSERT_RUN(a_fin_stopped, out_valid && out_data.finished |-> !out_data.playing)
    `KFLP_ASSERT_RUN(a_full_sticks, out_valid && out_data.store_full |-> sts.full)
    `KFLP_ASSERT_ALWAYS(a_div_in_state, sts.div_busy |-> (state == ST_DIV))
    `KFLP_ASSERT_RUN(a_div_after_start, cmd.div_start |=> sts.div_busy)

endmodule
